@@ rtl/linear_interp_resampler_assert.svh @@
// assertion helpers used by the resampler top module
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LIR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("resampler check failed");

// next-cycle implication, checked outside reset
`define LIR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("resampler check failed");

`endif

@@ rtl/lir_pkg.sv @@
package lir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 25;
  localparam int NCH_W      = 3;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int PROD_W     = 34;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [NCH_W-1:0]           nch_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  // position and step constants, Q9.16
  localparam pos_t ONE_Q16    = 25'd65536;
  localparam pos_t STEP_MIN   = 25'd1024;
  localparam pos_t STEP_MAX   = 25'd16777216;
  localparam pos_t STEP_RESET = 25'd65536;
  localparam nch_t NCH_RESET  = 3'd2;

  // control carried alongside the lane multiply stage
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

@@ rtl/lir_frame_if.sv @@
interface lir_frame_if import lir_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;

  modport source (output valid, output sample_0, output sample_1, output sample_2,
                  output sample_3, input ready);
  modport sink (input valid, input sample_0, input sample_1, input sample_2,
                input sample_3, output ready);
endinterface

@@ rtl/lir_result_if.sv @@
interface lir_result_if import lir_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_0;
  sample_t out_1;
  sample_t out_2;
  sample_t out_3;
  logic    last_of_run;

  modport source (output valid, output out_0, output out_1, output out_2, output out_3,
                  output last_of_run, input ready);
  modport sink (input valid, input out_0, input out_1, input out_2, input out_3,
                input last_of_run, output ready);
endinterface

@@ rtl/lir_lane.sv @@
module lir_lane import lir_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  sample_t             prev,
  input  sample_t             cur,
  input  logic [SAMPLE_W-1:0] pos,
  output sample_t             res
);

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod;
  sample_t                    prev_q;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [SAMPLE_W:0]   quo;
  logic signed [SAMPLE_W:0]   sum;

  // stage one: difference times fractional position
  assign diff      = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
  assign prod_full = PROD_W'($signed({1'b0, pos})) * PROD_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= prod_full;
      prev_q <= prev;
    end
  end

  // stage two: round to nearest, ties up, and add back the previous sample
  assign rnd = prod + PROD_W'(32768);
  assign quo = $signed(rnd[PROD_W-2:SAMPLE_W]);
  assign sum = {prev_q[SAMPLE_W-1], prev_q} + quo;
  assign res = sum[SAMPLE_W-1:0];

endmodule

@@ rtl/lir_merge.sv @@
module lir_merge import lir_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  sample_t      lane_res [CHANNELS],
  input  ctl_t         ctl,
  input  nch_t         nch,
  output logic         adv,
  lir_result_if.source result
);

  sample_t merged [LANES];

  // pipeline moves when the output register is free or being drained
  assign adv = !result.valid || result.ready;

  // inactive and absent channels read as zero
  for (genvar j = 0; j < LANES; j++) begin : g_mask
    if (j < CHANNELS) begin : g_live
      assign merged[j] = (NCH_W'(j) < nch) ? lane_res[j] : '0;
    end else begin : g_none
      assign merged[j] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_0       <= merged[0];
      result.out_1       <= merged[1];
      result.out_2       <= merged[2];
      result.out_3       <= merged[3];
      result.last_of_run <= ctl.last;
    end
  end

endmodule

@@ rtl/linear_interp_resampler.sv @@
// Linear-interpolation sample-rate converter: one multichannel frame per
// request in, zero or more interpolated frames out (prev + pos*(cur-prev),
// rounded), with last_of_run on the final output of each input frame. The
// first frame after reset primes the previous-frame store. An input frame
// causes n (0 to 64) outputs: the block takes the frame, gives one output per
// cycle while the Q9.16 read position stays below one and the output side
// keeps up, then wraps the position and retires the frame before it takes
// the next. Each channel has its own lane with a two-stage multiply and round
// pipeline; output stalls hold the whole pipe. The user writes step (register
// 0) and channels_in_use (register 1) through the wr_en/wr_index/wr_data port
// only while the block is idle; the block itself does not enforce this.
module linear_interp_resampler import lir_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  lir_frame_if.sink             frame,
  lir_result_if.source          result
);

  `include "linear_interp_resampler_assert.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic    state;
  pos_t    step;
  nch_t    channels_in_use;
  pos_t    pos;
  logic    primed;
  sample_t prev [CHANNELS];
  sample_t cur [CHANNELS];
  sample_t smp [LANES];
  sample_t lane_res [CHANNELS];
  ctl_t    ctl_s1;

  pos_t    st;
  nch_t    nch;
  pos_t    pos_sum;
  logic    accept;
  logic    issue;
  logic    issue_last;
  logic    adv;

  assign smp[0] = frame.sample_0;
  assign smp[1] = frame.sample_1;
  assign smp[2] = frame.sample_2;
  assign smp[3] = frame.sample_3;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= STEP_RESET;
      channels_in_use <= NCH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STEP:     step            <= wr_data[POS_W-1:0];
        REG_CHANNELS: channels_in_use <= wr_data[NCH_W-1:0];
        default:      ;
      endcase
    end
  end

  // clamp step and channel count
  always_comb begin
    if (step < STEP_MIN) begin
      st = STEP_MIN;
    end else if (step > STEP_MAX) begin
      st = STEP_MAX;
    end else begin
      st = step;
    end
    if (channels_in_use == '0) begin
      nch = NCH_W'(1);
    end else if (channels_in_use > NCH_W'(CHANNELS)) begin
      nch = NCH_W'(CHANNELS);
    end else begin
      nch = channels_in_use;
    end
  end

  // handshake and issue decisions
  assign frame.ready = (state == ST_IDLE);
  assign accept      = frame.valid && frame.ready;
  assign pos_sum     = pos + st;
  assign issue       = (state == ST_RUN) && (pos < ONE_Q16) && adv;
  assign issue_last  = (pos_sum >= ONE_Q16);

  // sequencer: take a frame, walk the position, retire the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pos    <= '0;
      primed <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state  <= ST_RUN;
            primed <= 1'b1;
          end
        end
        ST_RUN: begin
          if (pos >= ONE_Q16) begin
            pos   <= pos - ONE_Q16;
            state <= ST_IDLE;
          end else if (issue) begin
            pos <= pos_sum;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // frame stores
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (accept) begin
        cur[c] <= smp[c];
        if (!primed) begin
          prev[c] <= smp[c];
        end
      end else if (state == ST_RUN && pos >= ONE_Q16) begin
        prev[c] <= cur[c];
      end
    end
  end

  // control beside the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
    end else if (adv) begin
      ctl_s1.valid <= issue;
      ctl_s1.last  <= issue_last;
    end
  end

  // one interpolation lane per channel
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lir_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .prev (prev[g]),
      .cur  (cur[g]),
      .pos  (pos[SAMPLE_W-1:0]),
      .res  (lane_res[g])
    );
  end

  // combine lanes into the output register
  lir_merge #(.CHANNELS(CHANNELS)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .lane_res (lane_res),
    .ctl      (ctl_s1),
    .nch      (nch),
    .adv      (adv),
    .result   (result)
  );

  // position stays within one step of the frame boundary between frames
  `LIR_ASSERT_IMP(a_idle_pos, state == ST_IDLE, pos <= STEP_MAX)
  // an output not flagged last is followed by another output of the same frame
  `LIR_ASSERT_NXT(a_not_last, issue && !issue_last, state == ST_RUN && pos < ONE_Q16)
  // any accepted frame leaves the store primed
  `LIR_ASSERT_NXT(a_primed, accept, primed && state == ST_RUN)

endmodule
